FILE: src/swmtm_pkg.sv
package swmtm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RAIL_W   = 7;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL_HIGH   = 3'd4;

  localparam logic [1:0] MODE_RAW    = 2'd0;
  localparam logic [1:0] MODE_MEDIAN = 2'd1;

  localparam logic [RAIL_W-1:0] RAIL_MAX = 7'd127;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_RFIND,
    OP_RSHIFT,
    OP_IFIND,
    OP_ISHIFT,
    OP_IPUT,
    OP_SUM,
    OP_DIV,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic first;
  } cmd_t;

  typedef struct packed {
    logic removal;
    logic scan_end;
    logic div_done;
  } sts_t;

endpackage

FILE: src/swmtm_ctrl.sv
module swmtm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output swmtm_pkg::cmd_t cmd,
  input  swmtm_pkg::sts_t sts
);
  import swmtm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_AGE, S_RFIND, S_RSHIFT, S_IFIND, S_ISHIFT, S_IPUT, S_SUM, S_DIV, S_FIN
  } state_t;

  state_t state;
  logic   first;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd.first = first;
    unique case (state)
      S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_IDLE;
      S_AGE:    cmd.op = OP_IDLE;
      S_RFIND:  cmd.op = OP_RFIND;
      S_RSHIFT: cmd.op = OP_RSHIFT;
      S_IFIND:  cmd.op = OP_IFIND;
      S_ISHIFT: cmd.op = OP_ISHIFT;
      S_IPUT:   cmd.op = OP_IPUT;
      S_SUM:    cmd.op = OP_SUM;
      S_DIV:    cmd.op = OP_DIV;
      S_FIN:    cmd.op = out_free ? OP_OUT : OP_IDLE;
      default:  cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      first     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      first <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_AGE;
        end
        S_AGE: begin
          state <= sts.removal ? S_RFIND : S_IFIND;
          first <= 1'b1;
        end
        S_RFIND: begin
          if (!first && sts.scan_end) begin
            state <= S_RSHIFT;
            first <= 1'b1;
          end
        end
        S_RSHIFT: begin
          if (!first && sts.scan_end) begin
            state <= S_IFIND;
            first <= 1'b1;
          end
        end
        S_IFIND: begin
          if (!first && sts.scan_end) begin
            state <= S_ISHIFT;
            first <= 1'b1;
          end
        end
        S_ISHIFT: begin
          if (!first && sts.scan_end) state <= S_IPUT;
        end
        S_IPUT: begin
          state <= S_SUM;
          first <= 1'b1;
        end
        S_SUM: begin
          if (!first && sts.scan_end) begin
            state <= S_DIV;
            first <= 1'b1;
          end
        end
        S_DIV: begin
          if (!first && sts.div_done) state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_AGE))
    else $error("accepted word did not start processing");
  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished result not presented");
  a_busy_no_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_AGE) |-> (cmd.op == OP_IDLE))
    else $error("datapath commanded while fetching evictee");
`endif

endmodule

FILE: src/swmtm_dp.sv
module swmtm_dp #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [swmtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swmtm_pkg::CFG_W-1:0]      cfg_data,
  input  logic [swmtm_pkg::SAMPLE_W-1:0]   sample,
  output logic [swmtm_pkg::SAMPLE_W-1:0]   filtered,
  output logic [swmtm_pkg::RAIL_W-1:0]     rail_count,
  input  swmtm_pkg::cmd_t                  cmd,
  output swmtm_pkg::sts_t                  sts
);
  import swmtm_pkg::*;

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int SW    = (CW > 7) ? CW : 7;
  localparam int TW    = SW + 1;
  localparam int SUM_W = SAMPLE_W + CW;
  localparam int DW    = $clog2(SUM_W + 1);

  // configuration
  logic [6:0]          win_len;
  logic [5:0]          trim_len;
  logic [1:0]          mode_sel;
  logic [SAMPLE_W-1:0] thresh_lo;
  logic [SAMPLE_W-1:0] thresh_hi;

  // window state
  logic [SAMPLE_W-1:0] sorted_mem [MAX_WINDOW];
  logic [SAMPLE_W-1:0] age_mem [MAX_WINDOW];
  logic [CW-1:0]       fill_count;
  logic [AW-1:0]       write_slot;
  logic [CW-1:0]       previous_size;

  // per-word working registers
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] old_word;
  logic                removal;
  logic [SAMPLE_W-1:0] rd_data;
  logic [CW-1:0]       idx;
  logic [AW-1:0]       pidx;
  logic                v;
  logic                found;
  logic [CW-1:0]       pos;
  logic [CW-1:0]       trim;
  logic [CW-1:0]       kept;
  logic [SUM_W-1:0]    sum;
  logic [RAIL_W-1:0]   rails;
  logic [SAMPLE_W-1:0] lo;
  logic [SAMPLE_W-1:0] hi;
  logic [SUM_W-1:0]    num;
  logic [CW-1:0]       rem;
  logic [DW-1:0]       step;

  // load decode
  logic [SW-1:0] ws_w;
  logic [CW-1:0] size_c;
  logic          restart;
  logic [CW-1:0] n_eff;
  logic [AW-1:0] slot_eff;
  logic [AW-1:0] slot_next;

  always_comb begin
    ws_w = SW'(win_len);
    if (ws_w == '0) size_c = CW'(1);
    else if (ws_w > SW'(MAX_WINDOW)) size_c = CW'(MAX_WINDOW);
    else size_c = CW'(ws_w);
    restart = (size_c != previous_size);
    if (restart) n_eff = '0;
    else if (fill_count > size_c) n_eff = size_c;
    else n_eff = fill_count;
    if (restart || (CW'(write_slot) >= size_c)) slot_eff = '0;
    else slot_eff = write_slot;
    if ((CW'(slot_eff) + 1'b1) >= size_c) slot_next = '0;
    else slot_next = slot_eff + 1'b1;
  end

  // trim clamp
  logic [CW-1:0] trim_calc;
  always_comb begin
    if (TW'({trim_len, 1'b0}) >= TW'(fill_count))
      trim_calc = CW'((fill_count - 1'b1) >> 1);
    else
      trim_calc = CW'(trim_len);
  end

  // memory port decode
  logic          issue;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [SAMPLE_W-1:0] wdata;
  logic          run;

  assign run = !cmd.first;

  always_comb begin
    issue  = 1'b0;
    raddr  = AW'(idx);
    mem_we = 1'b0;
    waddr  = AW'(pos);
    wdata  = rd_data;
    unique case (cmd.op)
      OP_RFIND, OP_IFIND, OP_SUM: begin
        issue = run && (idx < fill_count);
      end
      OP_RSHIFT: begin
        issue  = run && (idx < fill_count);
        mem_we = run && v;
        waddr  = pidx - 1'b1;
      end
      OP_ISHIFT: begin
        issue  = run && (idx > pos);
        raddr  = AW'(idx - 1'b1);
        mem_we = run && v;
        waddr  = pidx + 1'b1;
      end
      OP_IPUT: begin
        mem_we = 1'b1;
        waddr  = AW'(pos);
        wdata  = sample_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.removal  = removal;
    sts.div_done = (step == DW'(SUM_W));
    unique case (cmd.op)
      OP_RFIND, OP_IFIND: sts.scan_end = found || (idx == fill_count && !v);
      OP_ISHIFT:          sts.scan_end = (idx == pos) && !v;
      default:            sts.scan_end = (idx == fill_count) && !v;
    endcase
  end

  // divider step
  logic [CW:0]   rem_sh;
  logic          ge;
  assign rem_sh = {rem, num[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, kept});

  // median
  logic [SAMPLE_W:0] mid_sum;
  logic [SAMPLE_W-1:0] median;
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign median  = fill_count[0] ? lo : mid_sum[SAMPLE_W:1];

  always_ff @(posedge clk) begin
    if (mem_we) sorted_mem[waddr] <= wdata;
    rd_data <= sorted_mem[raddr];
    if (cmd.op == OP_LOAD) begin
      old_word <= age_mem[slot_eff];
      age_mem[slot_eff] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len       <= 7'd1;
      trim_len      <= 6'd0;
      mode_sel      <= MODE_MEDIAN;
      thresh_lo     <= '0;
      thresh_hi     <= '1;
      fill_count    <= '0;
      write_slot    <= '0;
      previous_size <= '0;
      removal       <= 1'b0;
      v             <= 1'b0;
      found         <= 1'b0;
      idx           <= '0;
      step          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_SIZE: win_len   <= cfg_data[6:0];
          REG_TRIM_COUNT:  trim_len  <= cfg_data[5:0];
          REG_FILTER_MODE: mode_sel  <= cfg_data[1:0];
          REG_RAIL_LOW:    thresh_lo <= cfg_data;
          REG_RAIL_HIGH:   thresh_hi <= cfg_data;
          default: ;
        endcase
      end

      v    <= cmd.first ? 1'b0 : issue;
      pidx <= raddr;

      unique case (cmd.op)
        OP_LOAD: begin
          sample_r      <= sample;
          previous_size <= size_c;
          fill_count    <= n_eff;
          write_slot    <= slot_next;
          removal       <= (n_eff == size_c);
        end
        OP_RFIND: begin
          if (cmd.first) begin
            idx   <= '0;
            found <= 1'b0;
            pos   <= fill_count - 1'b1;
          end else begin
            if (issue) idx <= idx + 1'b1;
            if (v && !found && rd_data == old_word) begin
              found <= 1'b1;
              pos   <= CW'(pidx);
            end
          end
        end
        OP_RSHIFT: begin
          if (cmd.first) idx <= pos + 1'b1;
          else if (issue) idx <= idx + 1'b1;
        end
        OP_IFIND: begin
          if (cmd.first) begin
            idx   <= '0;
            found <= 1'b0;
            // drop the evicted word from the count
            if (removal) begin
              fill_count <= fill_count - 1'b1;
              pos        <= fill_count - 1'b1;
            end else begin
              pos <= fill_count;
            end
          end else begin
            if (issue) idx <= idx + 1'b1;
            if (v && !found && sample_r <= rd_data) begin
              found <= 1'b1;
              pos   <= CW'(pidx);
            end
          end
        end
        OP_ISHIFT: begin
          if (cmd.first) idx <= fill_count;
          else if (issue) idx <= idx - 1'b1;
        end
        OP_IPUT: begin
          fill_count <= fill_count + 1'b1;
        end
        OP_SUM: begin
          if (cmd.first) begin
            idx   <= '0;
            sum   <= '0;
            rails <= '0;
            trim  <= trim_calc;
            kept  <= fill_count - {trim_calc[CW-2:0], 1'b0};
          end else begin
            if (issue) idx <= idx + 1'b1;
            if (v) begin
              if (CW'(pidx) >= trim && CW'(pidx) < (fill_count - trim))
                sum <= sum + SUM_W'(rd_data);
              if ((rd_data <= thresh_lo || rd_data >= thresh_hi) && rails != RAIL_MAX)
                rails <= rails + 1'b1;
              if (CW'(pidx) == ((fill_count - 1'b1) >> 1)) lo <= rd_data;
              if (CW'(pidx) == (fill_count >> 1)) hi <= rd_data;
            end
          end
        end
        OP_DIV: begin
          if (cmd.first) begin
            num  <= sum + SUM_W'(kept >> 1);
            rem  <= '0;
            step <= '0;
          end else if (step != DW'(SUM_W)) begin
            rem  <= ge ? CW'(rem_sh - {1'b0, kept}) : rem_sh[CW-1:0];
            num  <= {num[SUM_W-2:0], ge};
            step <= step + 1'b1;
          end
        end
        OP_OUT: begin
          rail_count <= rails;
          unique case (mode_sel)
            MODE_RAW:    filtered <= sample_r;
            MODE_MEDIAN: filtered <= median;
            default:     filtered <= num[SAMPLE_W-1:0];
          endcase
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(MAX_WINDOW))
    else $error("window count beyond store depth");
  a_put_pos: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_IPUT) |-> (pos <= fill_count))
    else $error("insert position beyond window");
  a_kept_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV && !cmd.first) |-> (kept != '0))
    else $error("trimmed mean divisor is zero");
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_RSHIFT && mem_we) |-> (CW'(waddr) < fill_count))
    else $error("eviction shift writes outside window");
`endif

endmodule

FILE: src/sliding_window_median_trimmed_mean_unit.sv
// channel | signals                         | accepted when
// input   | in_valid, in_stall, sample      | in_valid && !in_stall
// output  | out_valid, out_stall, filtered, | out_valid && !out_stall
//         | rail_count                      |
// config  | cfg_we, cfg_index, cfg_data     | cfg_we
//
// Time per word is set by the walks over the sorted store (one read and one
// write port): evictee search and shift down when the window is full, insert
// search and shift up, sum; and by the bit-serial divider, one quotient bit per
// cycle.
// Synchronous active-high reset empties the window and loads register defaults.
// The input is stalled while a word is in progress; a waiting result does not
// hold up the next word until it is ready to be written out.
module sliding_window_median_trimmed_mean_unit #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [swmtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swmtm_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [swmtm_pkg::SAMPLE_W-1:0]   sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [swmtm_pkg::SAMPLE_W-1:0]   filtered,
  output logic [swmtm_pkg::RAIL_W-1:0]     rail_count
);
  import swmtm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  swmtm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  swmtm_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample),
    .filtered   (filtered),
    .rail_count (rail_count),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: verif/swmtm_checker.sv
`timescale 1ns / 1ps

module swmtm_checker
  import swmtm_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [SAMPLE_W-1:0]  filtered,
  input  logic [RAIL_W-1:0]    rail_count,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic [RAIL_W-1:0]   rails;
  } filter_out_t;

  // shadow registers
  logic [6:0]  win_reg;
  logic [5:0]  trim_reg;
  logic [1:0]  mode_reg;
  logic [15:0] low_reg;
  logic [15:0] high_reg;

  // shadow window
  logic [15:0] sorted_win [MAX_WINDOW];
  logic [15:0] age_win [MAX_WINDOW];
  int unsigned fill;
  int unsigned slot;
  int unsigned last_size;

  filter_out_t expected_q[$];

  function automatic filter_out_t filter_word(input logic [15:0] s);
    int unsigned size, n, pos, trim, kept, sum, rails, res, lo, hi;
    logic [15:0] old;
    logic        evict;
    filter_out_t r;
    size = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
    if (size != last_size) begin
      fill = 0;
      slot = 0;
      last_size = size;
    end
    evict = (fill == size);
    old = age_win[slot];
    age_win[slot] = s;
    slot = (slot + 1 >= size) ? 0 : slot + 1;
    n = fill;
    if (evict && n > 0) begin
      pos = n - 1;
      for (int i = 0; i < n; i++) begin
        if (sorted_win[i] == old) begin
          pos = i;
          break;
        end
      end
      for (int i = pos; i < n - 1; i++) sorted_win[i] = sorted_win[i+1];
      n--;
    end
    pos = n;
    for (int i = 0; i < n; i++) begin
      if (s <= sorted_win[i]) begin
        pos = i;
        break;
      end
    end
    for (int i = n; i > pos; i--) sorted_win[i] = sorted_win[i-1];
    sorted_win[pos] = s;
    n++;
    fill = n;
    trim = trim_reg;
    if (2 * trim >= n) trim = (n - 1) / 2;
    kept = n - 2 * trim;
    sum = 0;
    rails = 0;
    for (int i = 0; i < n; i++) begin
      if (i >= trim && i < n - trim) sum += sorted_win[i];
      if (sorted_win[i] <= low_reg || sorted_win[i] >= high_reg) rails++;
    end
    if (rails > RAIL_MAX) rails = RAIL_MAX;
    if (mode_reg == MODE_RAW) begin
      res = s;
    end else if (mode_reg == MODE_MEDIAN) begin
      lo = sorted_win[(n - 1) / 2];
      hi = sorted_win[n / 2];
      res = n[0] ? lo : (lo + hi) / 2;
    end else begin
      // trimmed mean, spare mode behaves the same
      res = (sum + kept / 2) / kept;
    end
    r.filtered = res[15:0];
    r.rails = rails[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    filter_out_t want;
    if (rst) begin
      win_reg = 7'd1;
      trim_reg = '0;
      mode_reg = MODE_MEDIAN;
      low_reg = '0;
      high_reg = 16'hFFFF;
      fill = 0;
      slot = 0;
      last_size = 0;
      expected_q.delete();
      fail_count <= 0;
      pending <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_SIZE: win_reg = cfg_data[6:0];
          REG_TRIM_COUNT:  trim_reg = cfg_data[5:0];
          REG_FILTER_MODE: mode_reg = cfg_data[1:0];
          REG_RAIL_LOW:    low_reg = cfg_data;
          REG_RAIL_HIGH:   high_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word filtered=%0d rail_count=%0d",
                   $time, filtered, rail_count);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.filtered !== filtered || want.rails !== rail_count) begin
            $display("%0t: mismatch expected filtered=%0d rail_count=%0d, got %0d %0d",
                     $time, want.filtered, want.rails, filtered, rail_count);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(filter_word(sample));
      pending <= expected_q.size();
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import swmtm_pkg::*;

  localparam logic [1:0] MODE_TRIMMED = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD  = 700;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SAMPLE_W-1:0]  filtered;
  logic [RAIL_W-1:0]    rail_count;

  int fail_count, pending, results_seen;
  int words_sent = 0;
  int phases = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  int burst_left = 0;
  bit calm = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sliding_window_median_trimmed_mean_unit DUT (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .sample,
    .out_valid, .out_stall, .filtered, .rail_count
  );

  swmtm_checker checker_i (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .sample,
    .out_valid, .out_stall, .filtered, .rail_count,
    .fail_count, .pending, .results_seen
  );

  // receiver: random stall bursts, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall <= (burst_left > 1);
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      burst_left <= $urandom_range(1, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one register write for a single edge; the caller drops the enable
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_filter(input int win, input int trim, input logic [1:0] mode,
                            input int lo, input int hi);
    reg_write(REG_WINDOW_SIZE, CFG_W'(win));
    reg_write(REG_TRIM_COUNT, CFG_W'(trim));
    reg_write(REG_FILTER_MODE, CFG_W'(mode));
    reg_write(REG_RAIL_LOW, CFG_W'(lo));
    reg_write(REG_RAIL_HIGH, CFG_W'(hi));
    cfg_we <= 1'b0;
    phases++;
  endtask

  // offer one word, with an optional random gap first
  task automatic send_word(input logic [15:0] v);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // drop valid and hold until every result is back
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample(input int style);
    case (style)
      0: return 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(65532, 65535));
      2: return 16'($urandom_range(100, 107));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int win, trim, lo, hi, len, style;
    logic [1:0] mode;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: single-sample median
    send_word(16'h0000);
    send_word(16'hFFFF);
    drain();
    // even median over a window of four
    set_filter(4, 0, MODE_MEDIAN, 10, 65000);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'hFFFE);
    send_word(16'h0001);
    send_word(16'h8000);
    drain();
    // trim too large, rounded trimmed mean
    set_filter(5, 63, MODE_TRIMMED, 0, 65535);
    send_word(16'd3);
    send_word(16'd4);
    send_word(16'hFFFF);
    send_word(16'd7);
    drain();
    // spare mode, raw mode, size zero and oversized
    set_filter(3, 1, MODE_SPARE, 65535, 0);
    send_word(16'd9);
    send_word(16'd9);
    send_word(16'd2);
    send_word(16'd9);
    drain();
    set_filter(0, 0, MODE_RAW, 1, 65534);
    send_word(16'h5555);
    send_word(16'hAAAA);
    drain();
    set_filter(127, 63, MODE_MEDIAN, 65535, 65535);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'hFFFF);
    drain();

    // random phases
    while (words_sent < 1900) begin
      case ($urandom_range(0, 5))
        0: win = $urandom_range(0, 1);
        1: win = $urandom_range(64, 127);
        2: win = $urandom_range(2, 64);
        default: win = $urandom_range(2, 12);
      endcase
      trim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
      mode = 2'($urandom_range(0, 3));
      lo = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 65535);
      hi = ($urandom_range(0, 1) == 0) ? $urandom_range(65527, 65535) : $urandom_range(0, 65535);
      // last stretch runs with no idling
      if (words_sent > 1700) calm = 1'b1;
      set_filter(win, trim, mode, lo, hi);
      len = $urandom_range(10, 90);
      style = $urandom_range(0, 4);
      for (int k = 0; k < len; k++) begin
        if (phases == 8 && k == 2) long_hold_req = 1'b1;
        send_word(pick_sample(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : style));
      end
      drain();
    end

    repeat (350) @(posedge clk);
    $display("sent %0d words over %0d register settings, %0d results checked",
             words_sent, phases, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: sliding_window_median_trimmed_mean_unit.f
src/swmtm_pkg.sv
src/swmtm_ctrl.sv
src/swmtm_dp.sv
src/sliding_window_median_trimmed_mean_unit.sv
verif/swmtm_checker.sv
verif/testbench.sv
